>>> hdl/mdlr_pkg.sv
// shared types and codes for the matrix duplicate line removal unit
`timescale 1ns / 1ps

package mdlr_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_REDUCE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam int CFG_W = 7;
    localparam int IDX_W = 6;
    localparam int VAL_W = 32;

    typedef struct packed {
        t_mode                    mode;
        logic signed [VAL_W-1:0]  elem_value;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0]  read_value;
        logic [CFG_W-1:0]         kept_rows;
        logic [CFG_W-1:0]         kept_cols;
        logic                     bad_index;
    } t_res;

endpackage

>>> hdl/mdlr_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module mdlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/matrix_duplicate_line_removal_unit.sv
// top level: matrix store with sequenced duplicate row and column removal
`timescale 1ns / 1ps
//
//  channel   ports                                   handshake
//  request   i_start, i_req (mdlr_pkg::t_req)        taken when i_start && !o_busy
//  result    o_valid, o_res (mdlr_pkg::t_res)        one cycle strobe, never held off
//  config    i_cfg_we, i_cfg_index, i_cfg_wdata      written when i_cfg_we is high
//
//  load leaves o_busy low; a bad read answers in the cycle after it is taken, a good
//  read passes S_RD_MAP, S_RD_ISSUE and S_RD_DATA (two map reads then one store read)
//  reduce: one shared store read port and comparator; per compared element the row
//  pass RW_RDA, RW_RDB, RW_CMP, the column pass CL_ROW, CL_LAT, CL_RDA, CL_RDB, CL_CMP,
//  plus START per candidate, MAP per kept line; o_busy stays high until the strobe
//  reset is synchronous, active low; stores are not cleared, there is no clearing pass

module matrix_duplicate_line_removal_unit #(
    parameter int MAX_DIM = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  mdlr_pkg::t_req                i_req,
    output logic                          o_busy,
    output logic                          o_valid,
    output mdlr_pkg::t_res                o_res,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [mdlr_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int DW    = $clog2(MAX_DIM);
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = CW + mdlr_pkg::CFG_W;

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_RW_START = 16'h0002,
        S_RW_MAP   = 16'h0004,
        S_RW_RDA   = 16'h0008,
        S_RW_RDB   = 16'h0010,
        S_RW_CMP   = 16'h0020,
        S_CL_START = 16'h0040,
        S_CL_MAP   = 16'h0080,
        S_CL_ROW   = 16'h0100,
        S_CL_LAT   = 16'h0200,
        S_CL_RDA   = 16'h0400,
        S_CL_RDB   = 16'h0800,
        S_CL_CMP   = 16'h1000,
        S_RD_MAP   = 16'h2000,
        S_RD_ISSUE = 16'h4000,
        S_RD_DATA  = 16'h8000
    } t_state;

    t_state r_state, n_state;

    logic [mdlr_pkg::CFG_W-1:0] r_rows_cfg, r_cols_cfg;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_x, n_x;
    logic [CW-1:0] r_kr, n_kr;
    logic [CW-1:0] r_kc, n_kc;
    logic          r_reduced, n_reduced;
    logic          r_out_valid, n_out_valid;

    logic [DW-1:0]                  r_ref, n_ref;
    logic [DW-1:0]                  r_line, n_line;
    logic [mdlr_pkg::VAL_W-1:0]     r_a, n_a;
    mdlr_pkg::t_res                 r_out, n_out;

    logic [CW-1:0] w_nr, w_nc;
    logic [CW-1:0] w_i_inc, w_k_inc, w_x_inc;
    logic          w_accept;
    logic          w_same;

    logic          w_m_we;
    logic [AW-1:0] w_m_waddr, w_m_raddr;
    logic [DW-1:0] w_mrow, w_mcol;
    logic [mdlr_pkg::VAL_W-1:0] w_m_rdata;

    logic          w_rm_we, w_cm_we;
    logic [DW-1:0] w_rm_raddr, w_cm_raddr;
    logic [DW-1:0] w_rm_rdata, w_cm_rdata;

    // dimension registers clamp to 1..MAX_DIM
    always_comb begin
        if (r_rows_cfg == '0) begin
            w_nr = CW'(1);
        end else if (EW'(r_rows_cfg) > EW'(MAX_DIM)) begin
            w_nr = CW'(MAX_DIM);
        end else begin
            w_nr = CW'(r_rows_cfg);
        end
        if (r_cols_cfg == '0) begin
            w_nc = CW'(1);
        end else if (EW'(r_cols_cfg) > EW'(MAX_DIM)) begin
            w_nc = CW'(MAX_DIM);
        end else begin
            w_nc = CW'(r_cols_cfg);
        end
    end

    assign w_i_inc  = r_i + CW'(1);
    assign w_k_inc  = r_k + CW'(1);
    assign w_x_inc  = r_x + CW'(1);
    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_same   = (r_a == w_m_rdata);

    // store write on load, dropped when outside the store
    assign w_m_we = w_accept && (i_req.mode == mdlr_pkg::MODE_LOAD)
                    && (EW'(i_req.row_index) < EW'(MAX_DIM))
                    && (EW'(i_req.col_index) < EW'(MAX_DIM));
    assign w_m_waddr = AW'(AW'(DW'(i_req.row_index)) * AW'(MAX_DIM)
                           + AW'(DW'(i_req.col_index)));

    // shared store read address
    always_comb begin
        case (r_state)
            S_RW_RDA: begin
                w_mrow = r_ref;
                w_mcol = r_x[DW-1:0];
            end
            S_RW_RDB: begin
                w_mrow = r_i[DW-1:0];
                w_mcol = r_x[DW-1:0];
            end
            S_CL_RDB: begin
                w_mrow = r_line;
                w_mcol = r_i[DW-1:0];
            end
            default: begin
                w_mrow = r_line;
                w_mcol = r_ref;
            end
        endcase
    end
    assign w_m_raddr = AW'(AW'(w_mrow) * AW'(MAX_DIM) + AW'(w_mcol));

    always_comb begin
        case (r_state)
            S_IDLE:     w_rm_raddr = DW'(i_req.row_index);
            S_RW_START: w_rm_raddr = '0;
            S_RW_CMP:   w_rm_raddr = w_k_inc[DW-1:0];
            S_CL_ROW:   w_rm_raddr = r_x[DW-1:0];
            default:    w_rm_raddr = r_k[DW-1:0];
        endcase
        case (r_state)
            S_IDLE:     w_cm_raddr = DW'(i_req.col_index);
            S_CL_START: w_cm_raddr = '0;
            S_CL_CMP:   w_cm_raddr = w_k_inc[DW-1:0];
            default:    w_cm_raddr = r_k[DW-1:0];
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_k         = r_k;
        n_x         = r_x;
        n_kr        = r_kr;
        n_kc        = r_kc;
        n_reduced   = r_reduced;
        n_out_valid = 1'b0;
        n_ref       = r_ref;
        n_line      = r_line;
        n_a         = r_a;
        n_out       = r_out;
        w_rm_we     = 1'b0;
        w_cm_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.mode)
                        mdlr_pkg::MODE_REDUCE: begin
                            n_i     = '0;
                            n_kr    = '0;
                            n_kc    = '0;
                            n_state = S_RW_START;
                        end
                        mdlr_pkg::MODE_READ: begin
                            if (!r_reduced
                                || (EW'(i_req.row_index) >= EW'(r_kr))
                                || (EW'(i_req.col_index) >= EW'(r_kc))) begin
                                n_out_valid     = 1'b1;
                                n_out.read_value = '0;
                                n_out.kept_rows = mdlr_pkg::CFG_W'(r_kr);
                                n_out.kept_cols = mdlr_pkg::CFG_W'(r_kc);
                                n_out.bad_index = 1'b1;
                            end else begin
                                n_state = S_RD_MAP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RW_START: begin
                n_k = '0;
                if (r_i == w_nr) begin
                    n_i     = '0;
                    n_state = S_CL_START;
                end else if (r_kr == '0) begin
                    w_rm_we = 1'b1;
                    n_kr    = r_kr + CW'(1);
                    n_i     = w_i_inc;
                end else begin
                    n_state = S_RW_MAP;
                end
            end
            S_RW_MAP: begin
                n_ref   = w_rm_rdata;
                n_x     = '0;
                n_state = S_RW_RDA;
            end
            S_RW_RDA: begin
                n_state = S_RW_RDB;
            end
            S_RW_RDB: begin
                n_a     = w_m_rdata;
                n_state = S_RW_CMP;
            end
            S_RW_CMP: begin
                if (w_same) begin
                    if (w_x_inc == w_nc) begin
                        // duplicate of a kept row
                        n_i     = w_i_inc;
                        n_state = S_RW_START;
                    end else begin
                        n_x     = w_x_inc;
                        n_state = S_RW_RDA;
                    end
                end else if (w_k_inc == r_kr) begin
                    w_rm_we = 1'b1;
                    n_kr    = r_kr + CW'(1);
                    n_i     = w_i_inc;
                    n_state = S_RW_START;
                end else begin
                    n_k     = w_k_inc;
                    n_state = S_RW_MAP;
                end
            end
            S_CL_START: begin
                n_k = '0;
                if (r_i == w_nc) begin
                    n_reduced        = 1'b1;
                    n_out_valid      = 1'b1;
                    n_out.read_value = '0;
                    n_out.kept_rows  = mdlr_pkg::CFG_W'(r_kr);
                    n_out.kept_cols  = mdlr_pkg::CFG_W'(r_kc);
                    n_out.bad_index  = 1'b0;
                    n_state          = S_IDLE;
                end else if (r_kc == '0) begin
                    w_cm_we = 1'b1;
                    n_kc    = r_kc + CW'(1);
                    n_i     = w_i_inc;
                end else begin
                    n_state = S_CL_MAP;
                end
            end
            S_CL_MAP: begin
                n_ref   = w_cm_rdata;
                n_x     = '0;
                n_state = S_CL_ROW;
            end
            S_CL_ROW: begin
                n_state = S_CL_LAT;
            end
            S_CL_LAT: begin
                n_line  = w_rm_rdata;
                n_state = S_CL_RDA;
            end
            S_CL_RDA: begin
                n_state = S_CL_RDB;
            end
            S_CL_RDB: begin
                n_a     = w_m_rdata;
                n_state = S_CL_CMP;
            end
            S_CL_CMP: begin
                if (w_same) begin
                    if (w_x_inc == r_kr) begin
                        n_i     = w_i_inc;
                        n_state = S_CL_START;
                    end else begin
                        n_x     = w_x_inc;
                        n_state = S_CL_ROW;
                    end
                end else if (w_k_inc == r_kc) begin
                    w_cm_we = 1'b1;
                    n_kc    = r_kc + CW'(1);
                    n_i     = w_i_inc;
                    n_state = S_CL_START;
                end else begin
                    n_k     = w_k_inc;
                    n_state = S_CL_MAP;
                end
            end
            S_RD_MAP: begin
                n_line  = w_rm_rdata;
                n_ref   = w_cm_rdata;
                n_state = S_RD_ISSUE;
            end
            S_RD_ISSUE: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                n_out_valid      = 1'b1;
                n_out.read_value = w_m_rdata;
                n_out.kept_rows  = mdlr_pkg::CFG_W'(r_kr);
                n_out.kept_cols  = mdlr_pkg::CFG_W'(r_kc);
                n_out.bad_index  = 1'b0;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows_cfg  <= mdlr_pkg::CFG_W'(1);
            r_cols_cfg  <= mdlr_pkg::CFG_W'(1);
            r_i         <= '0;
            r_k         <= '0;
            r_x         <= '0;
            r_kr        <= '0;
            r_kc        <= '0;
            r_reduced   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_k         <= n_k;
            r_x         <= n_x;
            r_kr        <= n_kr;
            r_kc        <= n_kc;
            r_reduced   <= n_reduced;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mdlr_pkg::CFG_ROWS: r_rows_cfg <= i_cfg_wdata;
                    mdlr_pkg::CFG_COLS: r_cols_cfg <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ref  <= n_ref;
        r_line <= n_line;
        r_a    <= n_a;
        r_out  <= n_out;
    end

    mdlr_ram #(
        .WIDTH (mdlr_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_m_we),
        .i_waddr (w_m_waddr),
        .i_wdata (i_req.elem_value),
        .i_raddr (w_m_raddr),
        .o_rdata (w_m_rdata)
    );

    mdlr_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_DIM)
    ) u_row_map (
        .i_clk   (i_clk),
        .i_we    (w_rm_we),
        .i_waddr (r_kr[DW-1:0]),
        .i_wdata (r_i[DW-1:0]),
        .i_raddr (w_rm_raddr),
        .o_rdata (w_rm_rdata)
    );

    mdlr_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_DIM)
    ) u_col_map (
        .i_clk   (i_clk),
        .i_we    (w_cm_we),
        .i_waddr (r_kc[DW-1:0]),
        .i_wdata (r_i[DW-1:0]),
        .i_raddr (w_cm_raddr),
        .o_rdata (w_cm_rdata)
    );

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

`ifndef SYNTHESIS
    // results only leave once the sequencer is back at rest
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_IDLE))
        else $error("result strobe while sequencer active");

    // a finished reduce always keeps at least one row and one column
    a_kept_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && r_reduced) |-> ((r_kr != '0) && (r_kc != '0)))
        else $error("reduce left an empty matrix");

    // kept lines never outrun the candidate line index
    a_map_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rm_we |-> (r_kr <= r_i)) and (w_cm_we |-> (r_kc <= r_i)))
        else $error("map write beyond candidate index");

    // an accepted reduce request always raises busy
    a_reduce_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.mode == mdlr_pkg::MODE_REDUCE)) |=> o_busy)
        else $error("reduce request did not start the sequencer");
`endif

endmodule

>>> dv/tb_matrix_duplicate_line_removal_unit.sv
// testbench for the matrix duplicate line removal unit: directed and random requests
`timescale 1ns / 1ps

module tb_matrix_duplicate_line_removal_unit;
    import mdlr_pkg::*;

    localparam int MAX_DIM      = 64;
    localparam int SETTLE       = 12;
    localparam int TOTAL_REQS   = 1050;
    localparam int QUIET_LIMIT  = 1_600_000;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    t_req               i_req;
    logic               o_busy;
    logic               o_valid;
    t_res               o_res;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_wdata;

    // shadow of the block state
    logic signed [VAL_W-1:0] elem_mem [MAX_DIM][MAX_DIM];
    int                      row_sel [MAX_DIM];
    int                      col_sel [MAX_DIM];
    int                      kept_r = 0;
    int                      kept_c = 0;
    bit                      dedup_done = 1'b0;
    logic [CFG_W-1:0]        rows_reg = 7'd1;
    logic [CFG_W-1:0]        cols_reg = 7'd1;

    t_res   res_q[$];
    bit     sender_gaps = 1'b1;
    int     n_errors = 0;
    int     n_sent = 0;
    int     n_checked = 0;
    int     n_loads = 0;
    int     n_reduces = 0;
    int     n_reads = 0;
    int     n_bad_reads = 0;
    int     n_ignored = 0;
    int     n_shapes = 0;
    int     quiet_cycles = 0;

    matrix_duplicate_line_removal_unit #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_valid     (o_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int eff_dim(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // keep first of each equal row, then first of each equal column over kept rows
    function automatic void run_dedup();
        int  nr;
        int  nc;
        bit  dup;
        bit  same;
        nr = eff_dim(rows_reg);
        nc = eff_dim(cols_reg);
        kept_r = 0;
        for (int r = 0; r < nr; r++) begin
            dup = 1'b0;
            for (int k = 0; k < kept_r && !dup; k++) begin
                same = 1'b1;
                for (int x = 0; x < nc; x++)
                    if (elem_mem[row_sel[k]][x] !== elem_mem[r][x]) same = 1'b0;
                dup = same;
            end
            if (!dup) begin
                row_sel[kept_r] = r;
                kept_r++;
            end
        end
        kept_c = 0;
        for (int c = 0; c < nc; c++) begin
            dup = 1'b0;
            for (int k = 0; k < kept_c && !dup; k++) begin
                same = 1'b1;
                for (int x = 0; x < kept_r; x++)
                    if (elem_mem[row_sel[x]][col_sel[k]] !== elem_mem[row_sel[x]][c])
                        same = 1'b0;
                dup = same;
            end
            if (!dup) begin
                col_sel[kept_c] = c;
                kept_c++;
            end
        end
        dedup_done = 1'b1;
    endfunction

    function automatic void predict_request(t_req q);
        t_res want;
        int   rr;
        int   cc;
        want = '0;
        rr = int'(q.row_index);
        cc = int'(q.col_index);
        case (q.mode)
            MODE_LOAD: begin
                elem_mem[rr][cc] = q.elem_value;
                n_loads++;
            end
            MODE_REDUCE: begin
                run_dedup();
                want.kept_rows = kept_r[CFG_W-1:0];
                want.kept_cols = kept_c[CFG_W-1:0];
                res_q.push_back(want);
                n_reduces++;
            end
            MODE_READ: begin
                if (!dedup_done || rr >= kept_r || cc >= kept_c) begin
                    want.bad_index = 1'b1;
                    n_bad_reads++;
                end else begin
                    want.read_value = elem_mem[row_sel[rr]][col_sel[cc]];
                end
                want.kept_rows = kept_r[CFG_W-1:0];
                want.kept_cols = kept_c[CFG_W-1:0];
                res_q.push_back(want);
                n_reads++;
            end
            default: n_ignored++;
        endcase
    endfunction

    function automatic t_req mk_req(t_mode m, logic signed [VAL_W-1:0] v, int r, int c);
        t_req q;
        q.mode       = m;
        q.elem_value = v;
        q.row_index  = r[IDX_W-1:0];
        q.col_index  = c[IDX_W-1:0];
        return q;
    endfunction

    function automatic logic signed [VAL_W-1:0] rnd_val();
        case ($urandom_range(5))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2, 3: return $urandom_range(4) - 2;
            default: return $urandom;
        endcase
    endfunction

    function automatic void report_mismatch(string why, t_res want, t_res got);
        n_errors++;
        if (n_errors <= 10)
            $display({"mismatch%s: want val=%0d rows=%0d cols=%0d bad=%0b,",
                      " got val=%0d rows=%0d cols=%0d bad=%0b"},
                     why, want.read_value, want.kept_rows, want.kept_cols, want.bad_index,
                     got.read_value, got.kept_rows, got.kept_cols, got.bad_index);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_res  want;
        string fields;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (res_q.size() == 0) begin
                report_mismatch(" (result with no request pending)", '0, o_res);
            end else begin
                want = res_q.pop_front();
                fields = "";
                if (o_res.read_value !== want.read_value) fields = {fields, " read_value"};
                if (o_res.kept_rows !== want.kept_rows) fields = {fields, " kept_rows"};
                if (o_res.kept_cols !== want.kept_cols) fields = {fields, " kept_cols"};
                if (o_res.bad_index !== want.bad_index) fields = {fields, " bad_index"};
                if (fields != "") report_mismatch({" in", fields}, want, o_res);
                n_checked++;
            end
        end
    end

    // counts cycles in which no request is taken and no result appears
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_req(input t_req q);
        if (sender_gaps) begin
            while ($urandom_range(99) < 21) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_req   <= q;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_request(q);
        n_sent++;
    endtask

    // wait until every result is in and the block has gone quiet
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (res_q.size() != 0 || o_busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == CFG_ROWS) rows_reg = val;
        else cols_reg = val;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_read_before_reduce();
        drain();
        send_req(mk_req(MODE_READ, VAL_MAX, 0, 0));
        send_req(mk_req(MODE_READ, VAL_MIN, 63, 63));
    endtask

    task automatic test_small_matrix();
        logic signed [VAL_W-1:0] line_a [4];
        logic signed [VAL_W-1:0] line_b [4];
        line_a = '{VAL_MIN, 7, VAL_MAX, 7};
        line_b = '{VAL_MIN, -1, VAL_MAX, -1};
        drain();
        write_reg(CFG_ROWS, 7'd3);
        write_reg(CFG_COLS, 7'd4);
        n_shapes++;
        // row 1 repeats row 0, columns 1 and 3 agree on the kept rows
        for (int c = 0; c < 4; c++) begin
            send_req(mk_req(MODE_LOAD, line_a[c], 0, c));
            send_req(mk_req(MODE_LOAD, line_a[c], 1, c));
            send_req(mk_req(MODE_LOAD, line_b[c], 2, c));
        end
        send_req(mk_req(MODE_REDUCE, VAL_MAX, 63, 63));
        send_req(mk_req(MODE_READ, 0, 0, 0));
        send_req(mk_req(MODE_READ, 0, 1, 1));
        send_req(mk_req(MODE_READ, 0, 1, 2));
        send_req(mk_req(MODE_READ, 0, 2, 0));
        send_req(mk_req(MODE_READ, 0, 0, 3));
        send_req(mk_req(MODE_READ, -1, 63, 63));
        send_req(mk_req(MODE_NONE, VAL_MIN, 1, 1));
        // load after reduce is seen through the old maps
        send_req(mk_req(MODE_LOAD, 0, 2, 1));
        send_req(mk_req(MODE_READ, 0, 1, 1));
    endtask

    task automatic test_dimension_limits();
        logic signed [VAL_W-1:0] v;
        drain();
        // zero acts as one, anything above the maximum as the maximum
        write_reg(CFG_ROWS, 7'd0);
        write_reg(CFG_COLS, 7'd127);
        n_shapes++;
        for (int c = 0; c < MAX_DIM; c++) begin
            v = (c % 7 == 3) ? VAL_MIN : (c == 63) ? VAL_MAX : c % 4;
            send_req(mk_req(MODE_LOAD, v, 0, c));
        end
        send_req(mk_req(MODE_REDUCE, 0, 0, 0));
        send_req(mk_req(MODE_READ, 0, 0, 0));
        send_req(mk_req(MODE_READ, 0, 0, kept_c - 1));
        send_req(mk_req(MODE_READ, 0, 0, kept_c));
        send_req(mk_req(MODE_READ, 0, 1, 0));
        drain();
        write_reg(CFG_ROWS, 7'd127);
        write_reg(CFG_COLS, 7'd0);
        n_shapes++;
        for (int r = 0; r < MAX_DIM; r++) begin
            v = (r == 10) ? -1 : (r == 40) ? VAL_MAX : r % 5;
            send_req(mk_req(MODE_LOAD, v, r, 0));
        end
        send_req(mk_req(MODE_REDUCE, 0, 0, 0));
        send_req(mk_req(MODE_READ, 0, kept_r - 1, 0));
        send_req(mk_req(MODE_READ, 0, kept_r, 0));
        send_req(mk_req(MODE_READ, 0, 0, 1));
    endtask

    // fill the active area from a few base rows and columns so that duplicates are common
    task automatic fill_matrix(input int nr, input int nc);
        logic signed [VAL_W-1:0] base [MAX_DIM][MAX_DIM];
        int  rpick [MAX_DIM];
        int  cpick [MAX_DIM];
        int  nbr;
        int  nbc;
        bit  narrow;
        bit  by_col;
        logic signed [VAL_W-1:0] v;
        nbr = $urandom_range(1, nr);
        nbc = $urandom_range(1, nc);
        narrow = 1'($urandom_range(1));
        by_col = 1'($urandom_range(1));
        for (int i = 0; i < nbr; i++)
            for (int j = 0; j < nbc; j++)
                base[i][j] = narrow ? $urandom_range(2) - 1 : rnd_val();
        for (int r = 0; r < nr; r++) rpick[r] = $urandom_range(nbr - 1);
        for (int c = 0; c < nc; c++) cpick[c] = $urandom_range(nbc - 1);
        for (int a = 0; a < (by_col ? nc : nr); a++) begin
            for (int b = 0; b < (by_col ? nr : nc); b++) begin
                v = by_col ? base[rpick[b]][cpick[a]] : base[rpick[a]][cpick[b]];
                // an odd element now and then makes near duplicates
                if ($urandom_range(31) == 0) v = rnd_val();
                if (by_col) send_req(mk_req(MODE_LOAD, v, b, a));
                else send_req(mk_req(MODE_LOAD, v, a, b));
            end
        end
    endtask

    task automatic test_random_shapes();
        int nr;
        int nc;
        int nops;
        int k;
        int rr;
        int cc;
        int ph;
        logic [CFG_W-1:0] rv;
        logic [CFG_W-1:0] cv;
        ph = 0;
        while (n_sent < TOTAL_REQS) begin
            case ($urandom_range(9))
                0: begin nr = MAX_DIM; nc = $urandom_range(1, 3); end
                1: begin nr = $urandom_range(1, 3); nc = MAX_DIM; end
                default: begin nr = $urandom_range(1, 8); nc = $urandom_range(1, 8); end
            endcase
            rv = CFG_W'(nr);
            cv = CFG_W'(nc);
            if (nr == 1 && $urandom_range(1)) rv = 0;
            if (nr == MAX_DIM && $urandom_range(1)) rv = CFG_W'($urandom_range(MAX_DIM, 127));
            if (nc == 1 && $urandom_range(1)) cv = 0;
            if (nc == MAX_DIM && $urandom_range(1)) cv = CFG_W'($urandom_range(MAX_DIM, 127));
            drain();
            if ($urandom_range(1)) begin
                write_reg(CFG_ROWS, rv);
                write_reg(CFG_COLS, cv);
            end else begin
                write_reg(CFG_COLS, cv);
                write_reg(CFG_ROWS, rv);
            end
            n_shapes++;
            sender_gaps = !(ph == 2 || ph == 3);
            // reads through the previous maps before the new area is reduced
            if ($urandom_range(3) == 0)
                send_req(mk_req(MODE_READ, rnd_val(), $urandom_range(kept_r),
                                $urandom_range(kept_c)));
            fill_matrix(nr, nc);
            send_req(mk_req(MODE_REDUCE, rnd_val(), $urandom_range(63), $urandom_range(63)));
            nops = $urandom_range(15, 40);
            for (int i = 0; i < nops; i++) begin
                k = $urandom_range(99);
                if (k < 10) begin
                    send_req(mk_req(MODE_REDUCE, rnd_val(), $urandom_range(63),
                                    $urandom_range(63)));
                end else if (k < 15) begin
                    send_req(mk_req(MODE_NONE, rnd_val(), $urandom_range(63),
                                    $urandom_range(63)));
                end else if (k < 28) begin
                    // overwrite inside the area with a copy of a neighbor
                    rr = $urandom_range(nr - 1);
                    cc = $urandom_range(nc - 1);
                    send_req(mk_req(MODE_LOAD,
                                    $urandom_range(1) ? elem_mem[$urandom_range(nr - 1)][cc]
                                                      : rnd_val(), rr, cc));
                end else if (k < 35) begin
                    send_req(mk_req(MODE_LOAD, rnd_val(), $urandom_range(63),
                                    $urandom_range(63)));
                end else if (k < 85) begin
                    send_req(mk_req(MODE_READ, rnd_val(), $urandom_range(kept_r - 1),
                                    $urandom_range(kept_c - 1)));
                end else begin
                    send_req(mk_req(MODE_READ, rnd_val(), $urandom_range(63),
                                    $urandom_range(63)));
                end
            end
            ph++;
        end
        sender_gaps = 1'b1;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_ROWS;
        i_cfg_wdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_read_before_reduce();
        test_small_matrix();
        test_dimension_limits();
        test_random_shapes();
        drain();
        repeat (20) @(posedge i_clk);
        $display("sent %0d requests: %0d loads, %0d reduces, %0d reads (%0d out of range)",
                 n_sent, n_loads, n_reduces, n_reads, n_bad_reads);
        $display("%0d ignored; checked %0d results over %0d matrix shapes, %0d mismatches",
                 n_ignored, n_checked, n_shapes, n_errors);
        if (n_errors == 0 && res_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
